[rtl/pbc_pkg.sv]
// Shared types and constants for the PRBS9 bit error rate checker.
// Used by pbc_cell and the top level; depends on nothing else.
package pbc_pkg;

	// Reference register: x^9 + x^5 + 1, taps at bits 4 and 8.
	localparam int LFSR_W   = 9;
	localparam int TAP_LOW  = 4;
	localparam int TAP_HIGH = 8;

	// Field and register widths.
	localparam int SIZE_W   = 16;
	localparam int SKIP_W   = 8;
	localparam int ERR_W    = 16;
	localparam int OUT_TOT_W = 32;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DAT_W = 16;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 80;

	// Register values after reset.
	localparam logic [SIZE_W-1:0] BLOCK_SIZE_RST  = 16'd1024;
	localparam logic [SKIP_W-1:0] SKIP_BLOCKS_RST = 8'd10;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BLOCK_SIZE  = 8'd0,
		CFG_SKIP_BLOCKS = 8'd1
	} pbc_cfg_idx_t;

	// Control shared by all cells of the reference register.
	typedef struct packed {
		logic en;    // advance the register by one bit
		logic load;  // take the seed instead of the stored bit
	} pbc_cell_ctrl_t;

endpackage

[rtl/pbc_cell.sv]
// One bit cell of the PRBS9 reference register.
// Depends on pbc_pkg for the shared control struct.
module pbc_cell
	import pbc_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  pbc_cell_ctrl_t ctrl,
	input  logic           seed_bit,   // this cell's bit of the seed
	input  logic           shift_in,   // current bit of the lower neighbor, or feedback
	output logic           cur         // bit as seen by this transfer
);

	logic bit_q;

	// At the first bit of a block the seed replaces the stored bit.
	assign cur = ctrl.load ? seed_bit : bit_q;

	// Shift by one position on every accepted bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= 1'b0;
		end else if (ctrl.en) begin
			bit_q <= shift_in;
		end
	end

endmodule

[rtl/prbs9_bit_error_rate_checker.sv]
// PRBS9 bit error rate checker: a row of nine pbc_cell reference cells, block counter and totals.
// A block result is registered and appears on the master side in the cycle after its last bit transfer.
// Throughput: one received bit per cycle; the input stalls only while a result waits.
// The reference register, the position counter and the totals all advance in the cycle
// of the bit transfer; the output register holds one result and frees itself when taken.
// Reset clears the counters and totals and loads block_size 1024 and skip_blocks 10.
module prbs9_bit_error_rate_checker
	import pbc_pkg::*;
#(
	parameter int POSITION_BITS = 16,
	parameter int TOTAL_BITS    = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Received bits.
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [0] rx_bit, [9:1] seed, rest zero
	// Block results.
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [15:0] block_errors,
	                                              // [47:16] total_errors,
	                                              // [79:48] blocks_counted
	output logic [0:0]            m_axis_tuser,   // [0] counted
	// Register writes.
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DAT_W-1:0]  cfg_data
);

	localparam int CMP_W  = (POSITION_BITS + 1 > SIZE_W) ? POSITION_BITS + 1 : SIZE_W;
	localparam int WIDE_W = (TOTAL_BITS > OUT_TOT_W) ? TOTAL_BITS : OUT_TOT_W;

	logic [SIZE_W-1:0]        block_size_q;
	logic [SKIP_W-1:0]        skip_left_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [ERR_W-1:0]         err_q;
	logic [TOTAL_BITS-1:0]    err_total_q;
	logic [TOTAL_BITS-1:0]    blk_total_q;
	logic                     out_valid_q;
	logic [ERR_W-1:0]         out_err_q;
	logic                     out_counted_q;
	logic [OUT_TOT_W-1:0]     out_err_total_q;
	logic [OUT_TOT_W-1:0]     out_blk_total_q;

	logic                     in_fire;
	logic                     rx_bit;
	logic [LFSR_W-1:0]        seed;
	logic [LFSR_W-1:0]        lfsr_cur;
	logic                     ref_bit;
	pbc_cell_ctrl_t           cell_ctrl;
	logic [ERR_W-1:0]         err_next;
	logic [POSITION_BITS:0]   pos_inc;
	logic                     block_end;
	logic                     counted;
	logic [TOTAL_BITS:0]      err_sum;
	logic [TOTAL_BITS-1:0]    err_total_next;
	logic [TOTAL_BITS-1:0]    blk_total_next;
	logic [WIDE_W-1:0]        err_total_wide;
	logic [WIDE_W-1:0]        blk_total_wide;

	// Input transfer and field unpacking.
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign rx_bit        = s_axis_tdata[0];
	assign seed          = s_axis_tdata[LFSR_W:1];
	assign cfg_ready     = 1'b1;

	assign cell_ctrl.en   = in_fire;
	assign cell_ctrl.load = (pos_q == '0);

	// Chain of reference cells; cell 0 takes the feedback bit.
	assign ref_bit = lfsr_cur[TAP_LOW] ^ lfsr_cur[TAP_HIGH];

	for (genvar i = 0; i < LFSR_W; i++) begin : g_cell
		pbc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (cell_ctrl),
			.seed_bit (seed[i]),
			.shift_in ((i == 0) ? ref_bit : lfsr_cur[(i == 0) ? 0 : i - 1]),
			.cur      (lfsr_cur[i])
		);
	end

	// Mismatch count for the block, saturating.
	assign err_next = ((ref_bit != rx_bit) && (err_q != '1)) ? err_q + 1'b1 : err_q;

	// Block ends when the position reaches the size or the counter is full.
	// A size of zero always satisfies the compare, so every bit ends a block.
	assign pos_inc   = {1'b0, pos_q} + 1'b1;
	assign block_end = (CMP_W'(pos_inc) >= CMP_W'(block_size_q)) || (&pos_q);
	assign counted   = (skip_left_q == '0);

	// Saturating totals.
	assign err_sum        = {1'b0, err_total_q} + (TOTAL_BITS + 1)'(err_next);
	assign err_total_next = err_sum[TOTAL_BITS] ? '1 : err_sum[TOTAL_BITS-1:0];
	assign blk_total_next = (blk_total_q == '1) ? blk_total_q : blk_total_q + 1'b1;

	// Clamp totals to the 32-bit output fields.
	assign err_total_wide = WIDE_W'(counted ? err_total_next : err_total_q);
	assign blk_total_wide = WIDE_W'(counted ? blk_total_next : blk_total_q);

	// Configuration, block state and totals.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q <= BLOCK_SIZE_RST;
			skip_left_q  <= SKIP_BLOCKS_RST;
			pos_q        <= '0;
			err_q        <= '0;
			err_total_q  <= '0;
			blk_total_q  <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_BLOCK_SIZE:  block_size_q <= cfg_data;
					CFG_SKIP_BLOCKS: skip_left_q  <= cfg_data[SKIP_W-1:0];
					default: ;
				endcase
			end
			if (in_fire) begin
				if (block_end) begin
					pos_q <= '0;
					err_q <= '0;
					if (counted) begin
						err_total_q <= err_total_next;
						blk_total_q <= blk_total_next;
					end else begin
						skip_left_q <= skip_left_q - 1'b1;
					end
				end else begin
					pos_q <= pos_inc[POSITION_BITS-1:0];
					err_q <= err_next;
				end
			end
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire && block_end) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (in_fire && block_end) begin
			out_err_q       <= err_next;
			out_counted_q   <= counted;
			out_err_total_q <= (err_total_wide > WIDE_W'({OUT_TOT_W{1'b1}})) ?
			                   '1 : err_total_wide[OUT_TOT_W-1:0];
			out_blk_total_q <= (blk_total_wide > WIDE_W'({OUT_TOT_W{1'b1}})) ?
			                   '1 : blk_total_wide[OUT_TOT_W-1:0];
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = {out_blk_total_q, out_err_total_q, out_err_q};
	assign m_axis_tuser[0] = out_counted_q;

	// A finished block restarts the position counter.
	a_block_restart: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && block_end |=> pos_q == '0)
		else $error("position counter did not restart after block end");

	// The input stalls only while a result is waiting.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> out_valid_q)
		else $error("input stalled with empty output register");

	// A block ending while blocks remain to skip is reported as not counted.
	a_skip_flag: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && block_end && skip_left_q != '0 |=> m_axis_tvalid && !m_axis_tuser[0])
		else $error("skipped block reported as counted");

	// The counted-block total never goes down.
	a_blocks_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> blk_total_q >= $past(blk_total_q))
		else $error("block total decreased");

endmodule
